// ===== rtl/bmrs_pkg.sv =====
// Package for the bus master request session block.
// Event codes, commands, frame constants and the answer validation function.
package bmrs_pkg;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_SUBMIT = 2'd1,
    CMD_BCAST  = 2'd2,
    CMD_DIRECT = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    EV_ACCEPTED   = 3'd0,
    EV_REJECTED   = 3'd1,
    EV_TRANSMIT   = 3'd2,
    EV_ANSWER     = 3'd3,
    EV_UNEXPECTED = 3'd4,
    EV_IRRELEVANT = 3'd5,
    EV_CONN_FAIL  = 3'd6
  } event_e;

  localparam logic [1:0] REG_ANSWER_TIMEOUT  = 2'd0;
  localparam logic [1:0] REG_UNICAST_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_MAX_RETRIES     = 2'd2;

  localparam logic [1:0] SLOT_BASIC  = 2'd0;
  localparam logic [1:0] SLOT_BCAST  = 2'd1;
  localparam logic [1:0] SLOT_DIRECT = 2'd2;

  localparam logic [5:0] ADDR_BROADCAST = 6'd0;
  localparam logic [5:0] ADDR_DIRECT    = 6'd63;
  localparam logic [1:0] TYPE_HP_SLAVE  = 2'd3;
  localparam logic [1:0] TYPE_HP_MASTER = 2'd2;
  localparam logic [1:0] TYPE_MASTER    = 2'd0;
  localparam logic [3:0] WR_RANGE_LEN   = 4'd2;

  localparam logic [3:0] FC_WR_RANGE  = 4'd0;
  localparam logic [3:0] FC_WR_SERIES = 4'd1;
  localparam logic [3:0] FC_RD_RANGE  = 4'd2;
  localparam logic [3:0] FC_RD_SERIES = 4'd3;

  typedef struct packed {
    logic [3:0] len;
    logic [1:0] ftype;
    logic [3:0] fcode;
    logic [5:0] addr;
  } hdr_t;

  typedef struct packed {
    logic [2:0]  ev;
    hdr_t        hdr;
    logic [63:0] payload;
  } res_t;

  function automatic logic [7:0] byte_at(input logic [63:0] p, input logic [3:0] i);
    byte_at = i[3] ? 8'd0 : p[{i[2:0], 3'b000} +: 8];
  endfunction

  // Check an answer frame against a stored request.
  function automatic logic relevant(input hdr_t rh, input logic [63:0] rp,
                                    input hdr_t ah, input logic [63:0] ap);
    logic       ok;
    logic [4:0] rl2;
    logic [4:0] al2;
    ok = 1'b0;
    rl2 = {rh.len, 1'b0};
    al2 = {ah.len, 1'b0};
    if (rh.addr != ADDR_BROADCAST && (rh.addr == ADDR_DIRECT || rh.addr == ah.addr)
        && rh.fcode == ah.fcode && ah.len != 4'd0) begin
      case (rh.fcode)
        FC_WR_RANGE: ok = ah.len == WR_RANGE_LEN && rp[15:0] == ap[15:0];
        FC_WR_SERIES: begin
          ok = {1'b0, rh.len} == al2;
          for (int i = 0; i < 8; i++) begin
            if (4'(i) < rh.len[3:1] && byte_at(rp, 4'(2 * i)) != byte_at(ap, 4'(i)))
              ok = 1'b0;
          end
        end
        FC_RD_RANGE: begin
          // al == rl + hi - lo + 1, computed in 10 bits unsigned (wrapping)
          ok = ({6'd0, ah.len} == 10'({6'd0, rh.len} + {1'b0, rp[15:8]}
                - {1'b0, rp[7:0]} + 10'd1)) && rp[15:0] == ap[15:0];
        end
        FC_RD_SERIES: begin
          ok = rl2 == {1'b0, ah.len};
          for (int i = 0; i < 8; i++) begin
            if (4'(i) < rh.len && byte_at(rp, 4'(i)) != byte_at(ap, 4'(2 * i)))
              ok = 1'b0;
          end
        end
        4'd4, 4'd5, 4'd6, 4'd7: ok = 1'b1;
        default: ok = 1'b0;
      endcase
    end
    relevant = ok;
  endfunction

endpackage

// ===== rtl/bmrs_out_queue.sv =====
// Two-entry result queue that splits a two-result item into two transfers.
// Depends on bmrs_pkg for the result record.
module bmrs_out_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  logic [1:0]     cnt_i,
  input  bmrs_pkg::res_t res0_i,
  input  bmrs_pkg::res_t res1_i,
  output logic           space_o,
  output logic           tvalid_o,
  input  logic           tready_i,
  output bmrs_pkg::res_t res_o,
  output logic           last_o
);
  import bmrs_pkg::*;

  res_t       ent_q [2];
  logic       lst_q [2];
  logic [1:0] cnt_q;
  logic       pop;

  assign pop      = tvalid_o && tready_i;
  assign tvalid_o = cnt_q != 2'd0;
  assign res_o    = ent_q[0];
  assign last_o   = lst_q[0];
  // accept only into an empty queue, or one draining its final entry now
  assign space_o  = cnt_q == 2'd0 || (cnt_q == 2'd1 && pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      if (push_i && cnt_i != 2'd0) begin
        cnt_q <= cnt_i;
      end else if (pop) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && cnt_i != 2'd0) begin
      ent_q[0] <= res0_i;
      lst_q[0] <= cnt_i == 2'd1;
      ent_q[1] <= res1_i;
      lst_q[1] <= 1'b1;
    end else if (pop) begin
      ent_q[0] <= ent_q[1];
      lst_q[0] <= lst_q[1];
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("result queue overfilled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !lst_q[0])
    else $error("first of two results flagged last");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tvalid_o && !tready_i) |=> tvalid_o)
    else $error("result dropped while stalled");
endmodule

// ===== rtl/bus_master_request_session.sv =====
// Top level of the bus master request session.
// Depends on bmrs_pkg and bmrs_out_queue.
//
// Usage: items enter on the s_axis channel (command, time, received frame,
// transmitter accept, submit fields), results leave on m_axis with tlast
// on the final result of an item. Registers are to be written over the cfg
// channel (index 0 answer timeout, 1 unicast timeout, 2 max retries) only
// while the block is idle; the block itself does not enforce this.
// Each item is processed in the cycle it is accepted; its results are
// registered into a two-entry output queue. A new item is accepted only once
// the queue is empty or its final result is being taken, so an item with two
// results must drain both first; throughput is set by the single output port.
// Reset clears the session state, pending flags and retry count and loads
// the register defaults. A stalled receiver holds the queue and s_axis_tready
// stays low until the final queued result is taken.
module bus_master_request_session #(
  parameter int TIME_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // tdata: command[1:0], time_now[33:2], frame_valid[34], tx_accept[35],
  // frame_address[41:36], frame_fcode[45:42], frame_type[47:46],
  // frame_length[51:48], frame_payload[115:52], high_priority[116], zero pad
  input  logic [((TIME_BITS+92)/8)*8-1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // tdata: event_res[2:0], out_address[8:3], out_fcode[12:9], out_type[14:13],
  // out_length[18:15], out_payload[82:19]
  output logic [87:0]          m_axis_tdata,
  output logic                 m_axis_tlast,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i
);
  import bmrs_pkg::*;

  localparam int TB = TIME_BITS;

  typedef enum logic [1:0] {
    ST_WAIT_REQ = 2'd0,
    ST_SENDING  = 2'd1,
    ST_WAIT_ANS = 2'd2,
    ST_WAIT_UNI = 2'd3
  } state_e;

  logic [31:0] ans_to_q, uni_to_q;
  logic [7:0]  max_retry_q;
  state_e      state_q, state_d;
  logic [2:0]  pend_q, pend_d;
  logic [1:0]  slot_q, slot_d;
  logic [TB-1:0] req_time_q, req_time_d;
  logic [7:0]  retry_q, retry_d;
  hdr_t        hdr_q [3];
  logic [63:0] pay_q [3];

  logic        accept, space;
  logic [1:0]  cmd;
  logic [TB-1:0] now, elapsed;
  logic        fv, txa, hp;
  hdr_t        fh;
  logic [63:0] fp;
  res_t        r0, r1, rq;
  logic [1:0]  n;
  logic        wr_en;
  logic [1:0]  wr_slot;
  hdr_t        wr_hdr;
  hdr_t        rh;
  logic [63:0] rp;
  logic        rel_basic, rel_direct;
  logic        ans_due, uni_due;

  assign cmd = s_axis_tdata[1:0];
  assign now = s_axis_tdata[TB+1:2];
  assign fv  = s_axis_tdata[TB+2];
  assign txa = s_axis_tdata[TB+3];
  assign fh.addr  = s_axis_tdata[TB+9:TB+4];
  assign fh.fcode = s_axis_tdata[TB+13:TB+10];
  assign fh.ftype = s_axis_tdata[TB+15:TB+14];
  assign fh.len   = s_axis_tdata[TB+19:TB+16];
  assign fp  = s_axis_tdata[TB+83:TB+20];
  assign hp  = s_axis_tdata[TB+84];

  assign s_axis_tready = space;
  assign accept = s_axis_tvalid && space;
  assign cfg_ready_o = 1'b1;

  assign elapsed = now - req_time_q;
  assign ans_due = 64'(elapsed) >= 64'(ans_to_q);
  assign uni_due = 64'(elapsed) >= 64'(uni_to_q);

  assign rh = hdr_q[slot_q];
  assign rp = pay_q[slot_q];
  assign rel_basic  = relevant(hdr_q[SLOT_BASIC], pay_q[SLOT_BASIC], fh, fp);
  assign rel_direct = relevant(hdr_q[SLOT_DIRECT], pay_q[SLOT_DIRECT], fh, fp);

  always_comb begin
    state_d = state_q;
    pend_d = pend_q;
    slot_d = slot_q;
    req_time_d = req_time_q;
    retry_d = retry_q;
    wr_en = 1'b0;
    wr_slot = SLOT_BASIC;
    wr_hdr = fh;
    r0 = '0;
    r1 = '0;
    n = 2'd0;
    rq = '0;
    if (cmd != CMD_TICK) begin
      n = 2'd1;
      r0.ev = EV_REJECTED;
      if (cmd == CMD_SUBMIT) begin
        if (fh.addr != ADDR_BROADCAST && fh.addr != ADDR_DIRECT) begin
          wr_en = 1'b1;
          pend_d[SLOT_BASIC] = 1'b1;
          r0.ev = EV_ACCEPTED;
        end
      end else begin
        wr_slot = (cmd == CMD_BCAST) ? SLOT_BCAST : SLOT_DIRECT;
        wr_hdr.addr = (cmd == CMD_BCAST) ? ADDR_BROADCAST : ADDR_DIRECT;
        wr_hdr.ftype = hp ? TYPE_HP_MASTER : TYPE_MASTER;
        if (!pend_q[wr_slot]) begin
          wr_en = 1'b1;
          pend_d[wr_slot] = 1'b1;
          r0.ev = EV_ACCEPTED;
        end
      end
    end else begin
      if ((state_q == ST_WAIT_REQ || state_q == ST_SENDING) && fv) begin
        rq.ev = (fh.ftype == TYPE_HP_SLAVE) ? EV_UNEXPECTED : EV_IRRELEVANT;
        rq.hdr = fh;
        rq.payload = fp;
        r0 = rq;
        n = 2'd1;
        rq = '0;
      end
      case (state_q)
        ST_WAIT_REQ: begin
          if (pend_q != 3'd0) begin
            slot_d = pend_q[SLOT_BCAST] ? SLOT_BCAST :
                     pend_q[SLOT_DIRECT] ? SLOT_DIRECT : SLOT_BASIC;
            pend_d[slot_d] = 1'b0;
            state_d = ST_SENDING;
          end
        end
        ST_SENDING: begin
          if (txa) begin
            rq.ev = EV_TRANSMIT;
            rq.hdr = rh;
            rq.payload = rp;
            if (rh.addr == ADDR_DIRECT) begin
              state_d = ST_WAIT_UNI;
              req_time_d = now;
            end else if (rh.addr == ADDR_BROADCAST) begin
              state_d = ST_WAIT_REQ;
            end else begin
              state_d = ST_WAIT_ANS;
              req_time_d = now;
            end
          end
        end
        ST_WAIT_ANS: begin
          if (!fv) begin
            if (ans_due) begin
              if (retry_q >= max_retry_q) begin
                retry_d = 8'd0;
                rq.ev = EV_CONN_FAIL;
                state_d = ST_WAIT_REQ;
              end else begin
                retry_d = retry_q + 8'd1;
                state_d = ST_SENDING;
              end
            end
          end else begin
            rq.hdr = fh;
            rq.payload = fp;
            if (fh.ftype == TYPE_HP_SLAVE) rq.ev = EV_UNEXPECTED;
            else if (!rel_basic) rq.ev = EV_IRRELEVANT;
            else begin
              rq.ev = EV_ANSWER;
              retry_d = 8'd0;
              state_d = ST_WAIT_REQ;
            end
          end
        end
        default: begin
          if (!fv) begin
            if (uni_due) state_d = ST_WAIT_REQ;
          end else begin
            rq.hdr = fh;
            rq.payload = fp;
            rq.ev = (fh.ftype == TYPE_HP_SLAVE || rel_direct) ? EV_UNEXPECTED
                                                              : EV_IRRELEVANT;
          end
        end
      endcase
      // a state event exists when rq was filled above; it follows a frame event, else it is first
      if (rq.ev != EV_ACCEPTED || (state_q == ST_SENDING && txa)) begin
        if (n == 2'd1) begin
          r1 = rq;
          n = 2'd2;
        end else begin
          r0 = rq;
          n = 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_WAIT_REQ;
      pend_q <= 3'd0;
      slot_q <= SLOT_BASIC;
      req_time_q <= '0;
      retry_q <= 8'd0;
      ans_to_q <= 32'd100;
      uni_to_q <= 32'd100;
      max_retry_q <= 8'd3;
    end else begin
      if (accept) begin
        state_q <= state_d;
        pend_q <= pend_d;
        slot_q <= slot_d;
        req_time_q <= req_time_d;
        retry_q <= retry_d;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_ANSWER_TIMEOUT:  ans_to_q <= cfg_data_i;
          REG_UNICAST_TIMEOUT: uni_to_q <= cfg_data_i;
          REG_MAX_RETRIES:     max_retry_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && wr_en) begin
      hdr_q[wr_slot] <= wr_hdr;
      pay_q[wr_slot] <= fp;
    end
  end

  res_t qres;

  bmrs_out_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (accept),
    .cnt_i    (n),
    .res0_i   (r0),
    .res1_i   (r1),
    .space_o  (space),
    .tvalid_o (m_axis_tvalid),
    .tready_i (m_axis_tready),
    .res_o    (qres),
    .last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, qres.payload, qres.hdr.len, qres.hdr.ftype,
                         qres.hdr.fcode, qres.hdr.addr, qres.ev};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd == CMD_TICK && state_q == ST_SENDING && !txa)
    |=> state_q == ST_SENDING)
    else $error("request left sending without transmitter accept");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd != CMD_TICK) |=> m_axis_tvalid)
    else $error("submit produced no result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && state_q == ST_WAIT_REQ && cmd == CMD_TICK && pend_q != 3'd0)
    |=> state_q == ST_SENDING)
    else $error("pending request not picked");
endmodule
